>>> rtl/nec_ir_pkg.sv
// Shared types and constants for the NEC infrared frame transmitter.
package nec_ir_pkg;

  localparam int CFG_DATA_W      = 12;
  localparam int CFG_INDEX_W     = 3;
  localparam int FRAME_PATTERN_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4
  } reg_index_t;

  localparam logic [CFG_DATA_W-1:0] HEADER_MARK_RESET  = 12'd553;
  localparam logic [CFG_DATA_W-1:0] HEADER_SPACE_RESET = 12'd282;
  localparam logic [CFG_DATA_W-1:0] BIT_MARK_RESET     = 12'd34;
  localparam logic [CFG_DATA_W-1:0] ONE_SPACE_RESET    = 12'd102;
  localparam logic [CFG_DATA_W-1:0] ZERO_SPACE_RESET   = 12'd34;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_MARK  = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_MARK  = 3'd3,
    PH_BIT_SPACE = 3'd4,
    PH_STOP_MARK = 3'd5
  } phase_t;

endpackage

>>> rtl/nec_ir_frame_transmitter_top.sv
// NEC infrared frame transmitter: tick-timed frame sequencer with registered result.
// An accepted item's result is in the output register in the next cycle.
// Throughput: one item per cycle; a result held by a low out_ready stalls the input.
// A start in idle or a tick while busy updates the phase sequencer and tick counter.
// Synchronous reset returns the sequencer to idle with pin_level high and loads
// the default timing registers; no clearing pass is needed. ir_level is not reset.
module nec_ir_frame_transmitter_top #(
  parameter int TICK_BITS  = 12,
  parameter int FRAME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [7:0]                          address,
  input  logic [7:0]                          payload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ir_level,
  output logic                                busy_res,
  output logic                                frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nec_ir_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nec_ir_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int BIT_W = $clog2(FRAME_BITS + 1);
  localparam int PAT_W = (FRAME_BITS > nec_ir_pkg::FRAME_PATTERN_W) ?
                         FRAME_BITS : nec_ir_pkg::FRAME_PATTERN_W;

  logic [TICK_BITS-1:0] header_mark_ticks;
  logic [TICK_BITS-1:0] header_space_ticks;
  logic [TICK_BITS-1:0] bit_mark_ticks;
  logic [TICK_BITS-1:0] one_space_ticks;
  logic [TICK_BITS-1:0] zero_space_ticks;

  nec_ir_pkg::phase_t    phase, phase_next;
  logic [TICK_BITS-1:0]  tick_count, tick_count_next;
  logic [BIT_W-1:0]      bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic                  pin_level, pin_level_next;
  logic                  done_next;

  logic                  in_fire;
  logic                  is_mark;
  logic [TICK_BITS-1:0]  phase_len;
  logic [TICK_BITS:0]    tick_inc;
  logic [BIT_W-1:0]      bit_inc;
  logic [nec_ir_pkg::FRAME_PATTERN_W-1:0] pattern;
  logic [PAT_W-1:0]      pattern_wide;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign pattern      = {~payload, payload, ~address, address};
  assign pattern_wide = PAT_W'(pattern);
  assign tick_inc     = {1'b0, tick_count} + {{TICK_BITS{1'b0}}, 1'b1};
  assign bit_inc      = bit_index + BIT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_ticks  <= TICK_BITS'(nec_ir_pkg::HEADER_MARK_RESET);
      header_space_ticks <= TICK_BITS'(nec_ir_pkg::HEADER_SPACE_RESET);
      bit_mark_ticks     <= TICK_BITS'(nec_ir_pkg::BIT_MARK_RESET);
      one_space_ticks    <= TICK_BITS'(nec_ir_pkg::ONE_SPACE_RESET);
      zero_space_ticks   <= TICK_BITS'(nec_ir_pkg::ZERO_SPACE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nec_ir_pkg::REG_HEADER_MARK:  header_mark_ticks  <= TICK_BITS'(cfg_data);
        nec_ir_pkg::REG_HEADER_SPACE: header_space_ticks <= TICK_BITS'(cfg_data);
        nec_ir_pkg::REG_BIT_MARK:     bit_mark_ticks     <= TICK_BITS'(cfg_data);
        nec_ir_pkg::REG_ONE_SPACE:    one_space_ticks    <= TICK_BITS'(cfg_data);
        nec_ir_pkg::REG_ZERO_SPACE:   zero_space_ticks   <= TICK_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    is_mark = (phase == nec_ir_pkg::PH_HDR_MARK) || (phase == nec_ir_pkg::PH_BIT_MARK) ||
              (phase == nec_ir_pkg::PH_STOP_MARK);
    unique case (phase)
      nec_ir_pkg::PH_HDR_MARK:  phase_len = header_mark_ticks;
      nec_ir_pkg::PH_HDR_SPACE: phase_len = header_space_ticks;
      nec_ir_pkg::PH_BIT_MARK:  phase_len = bit_mark_ticks;
      nec_ir_pkg::PH_BIT_SPACE: phase_len = frame_shift[0] ? one_space_ticks : zero_space_ticks;
      nec_ir_pkg::PH_STOP_MARK: phase_len = bit_mark_ticks;
      default:                  phase_len = TICK_BITS'(1);
    endcase

    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    frame_shift_next = frame_shift;
    pin_level_next   = pin_level;
    done_next        = 1'b0;

    if (in_fire) begin
      if (cmd == nec_ir_pkg::CMD_START) begin
        if (phase == nec_ir_pkg::PH_IDLE) begin
          frame_shift_next = pattern_wide[FRAME_BITS-1:0];
          phase_next       = nec_ir_pkg::PH_HDR_MARK;
          tick_count_next  = '0;
          bit_index_next   = '0;
          pin_level_next   = 1'b1;
        end
      end else if (phase != nec_ir_pkg::PH_IDLE) begin
        pin_level_next = is_mark ? ~pin_level : 1'b0;
        if (tick_inc[TICK_BITS] || (tick_inc[TICK_BITS-1:0] >= phase_len)) begin
          tick_count_next = '0;
          unique case (phase)
            nec_ir_pkg::PH_HDR_MARK:  phase_next = nec_ir_pkg::PH_HDR_SPACE;
            nec_ir_pkg::PH_HDR_SPACE: phase_next = nec_ir_pkg::PH_BIT_MARK;
            nec_ir_pkg::PH_BIT_MARK:  phase_next = nec_ir_pkg::PH_BIT_SPACE;
            nec_ir_pkg::PH_BIT_SPACE: begin
              frame_shift_next = frame_shift >> 1;
              bit_index_next   = bit_inc;
              phase_next       = (bit_inc >= BIT_W'(FRAME_BITS)) ?
                                 nec_ir_pkg::PH_STOP_MARK : nec_ir_pkg::PH_BIT_MARK;
            end
            default: begin
              phase_next     = nec_ir_pkg::PH_IDLE;
              pin_level_next = 1'b1;
              bit_index_next = '0;
              done_next      = 1'b1;
            end
          endcase
        end else begin
          tick_count_next = tick_inc[TICK_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= nec_ir_pkg::PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      frame_shift <= '0;
      pin_level   <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      frame_shift <= frame_shift_next;
      pin_level   <= pin_level_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ir_level   <= pin_level_next;
      busy_res   <= (phase_next != nec_ir_pkg::PH_IDLE);
      frame_done <= done_next;
    end
  end

endmodule
